@@ hdl/fpfm_pkg.sv @@
package fpfm_pkg;

  // Default sizes of the map.
  localparam int DEF_ENTRIES   = 16;
  localparam int DEF_PAGES     = 64;
  localparam int DEF_ADDR_BITS = 16;

  // Fixed widths of the interface fields.
  localparam int ADDR_W = 16;
  localparam int PG_W   = 7;
  // Page arithmetic width, one bit above the field width so sums never wrap.
  localparam int PN_W   = PG_W + 1;
  localparam int CFG_W  = 7;

  // Register indexes of the configuration port.
  localparam logic REG_MAP_MODE     = 1'b0;
  localparam logic REG_PAGES_IN_USE = 1'b1;

  // Commands.
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_SET   = 1'b1;

  // Map modes.
  localparam logic MODE_RANDOM      = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RESP
  } fpfm_state_t;

endpackage

@@ hdl/fpfm_row_ram.sv @@
module fpfm_row_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [DATA_W-1:0]                wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [DATA_W-1:0]                rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/flash_page_fill_map.sv @@
// A checked or set item, once accepted, runs through the scan, drain, decide and response states;
// an item whose range runs past the block goes straight to the response state.
// The block takes no new item until the last one has been answered and taken (out_stall low); each
// item walks the entry table through its single read port, one entry per cycle.
// Reset (synchronous, active high) clears all entry valid bits and the registers to
// random mode with 64 pages; table contents are not cleared.
module flash_page_fill_map #(
  parameter int ENTRIES   = fpfm_pkg::DEF_ENTRIES,
  parameter int PAGES     = fpfm_pkg::DEF_PAGES,
  parameter int ADDR_BITS = fpfm_pkg::DEF_ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [fpfm_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [fpfm_pkg::ADDR_W-1:0] block_address,
  input  logic [fpfm_pkg::PG_W-1:0]   page_offset,
  input  logic [fpfm_pkg::PG_W-1:0]   page_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        answer,
  output logic                        table_full
);
  import fpfm_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES > 1 ? ENTRIES : 2);
  localparam int TAG_W = ADDR_BITS < ADDR_W ? ADDR_BITS : ADDR_W;
  localparam int CNT_W = $clog2(PAGES + 1);
  localparam int ROW_W = TAG_W + PAGES + CNT_W;

  fpfm_state_t state, state_next;

  // Configuration registers.
  logic              map_mode;
  logic [CFG_W-1:0]  pages_in_use;

  // Latched item.
  logic              cmd_q;
  logic [TAG_W-1:0]  tag_q;
  logic [PN_W-1:0]   off_q;
  logic [PN_W-1:0]   cnt_q;

  // Table walk.
  logic [ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   cmp_idx;
  logic               cmp_vld;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [PAGES-1:0]   hit_bm;
  logic [CNT_W-1:0]   hit_cnt;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  // Result.
  logic ans_q;
  logic full_q;

  // Memory ports.
  logic [ROW_W-1:0]  rd_row;
  logic [TAG_W-1:0]  rd_tag;
  logic [PAGES-1:0]  rd_bm;
  logic [CNT_W-1:0]  rd_cnt;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [PAGES-1:0]  wr_bm;
  logic [CNT_W-1:0]  wr_cnt;

  // Decision outputs.
  logic              ans_c;
  logic              full_c;
  logic              vld_we;
  logic              vld_val;

  // Page masks and totals.
  logic [PN_W-1:0]   p8;
  logic [PN_W-1:0]   in_off8;
  logic [PN_W-1:0]   in_cnt8;
  logic              in_range_ok;
  logic [PAGES-1:0]  pmask;
  logic [PAGES-1:0]  rmask;
  logic              off_used;
  logic [PAGES-1:0]  used_bm;
  logic [PN_W-1:0]   ecnt8;
  logic [PN_W-1:0]   left8;
  logic [PN_W-1:0]   sum8;
  logic [PAGES-1:0]  base_bm;
  logic [CNT_W-1:0]  base_cnt;
  logic [PAGES-1:0]  new_bm;

  assign rd_tag = rd_row[ROW_W-1 -: TAG_W];
  assign rd_bm  = rd_row[CNT_W +: PAGES];
  assign rd_cnt = rd_row[CNT_W-1:0];

  // The table row is written only in the decision cycle.
  fpfm_row_ram #(
    .DEPTH  (ENTRIES),
    .DATA_W (ROW_W)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en && state == ST_DECIDE),
    .waddr (wr_idx),
    .wdata ({tag_q, wr_bm, wr_cnt}),
    .raddr (scan_idx),
    .rdata (rd_row)
  );

  // Effective page total, clamped to one through PAGES.
  always_comb begin
    if (pages_in_use == '0) begin
      p8 = PN_W'(1);
    end else if ({1'b0, pages_in_use} > PN_W'(PAGES)) begin
      p8 = PN_W'(PAGES);
    end else begin
      p8 = {1'b0, pages_in_use};
    end
  end

  assign in_off8     = {1'b0, page_offset};
  assign in_cnt8     = {1'b0, page_count};
  assign in_range_ok = (in_off8 + in_cnt8) <= p8;

  // Block and range masks, one bit per page.
  always_comb begin
    for (int j = 0; j < PAGES; j++) begin
      pmask[j] = PN_W'(j) < p8;
      rmask[j] = (PN_W'(j) >= off_q) && (PN_W'(j) < off_q + cnt_q);
    end
  end

  assign used_bm = hit_bm & pmask;

  // The page at the offset itself, when it lies inside the block.
  always_comb begin
    off_used = 1'b0;
    for (int j = 0; j < PAGES; j++) begin
      if (PN_W'(j) == off_q) begin
        off_used = used_bm[j];
      end
    end
  end

  assign ecnt8    = PN_W'(hit_cnt);
  assign left8    = ecnt8 < p8 ? p8 - ecnt8 : '0;
  assign base_bm  = hit_found ? hit_bm : '0;
  assign base_cnt = hit_found ? hit_cnt : '0;
  assign new_bm   = base_bm | rmask;
  assign sum8     = PN_W'(base_cnt) + cnt_q;

  // Decision for a walked item: answer, table update and valid bit update.
  always_comb begin
    ans_c   = 1'b0;
    full_c  = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = hit_found ? hit_idx : free_idx;
    wr_bm   = base_bm;
    wr_cnt  = base_cnt;
    vld_we  = 1'b0;
    vld_val = 1'b0;
    if (cmd_q == CMD_CHECK) begin
      if (hit_found) begin
        if (map_mode == MODE_RANDOM) begin
          ans_c = !off_used && ((used_bm & rmask) == '0);
        end else begin
          ans_c = (off_q == ecnt8) && (cnt_q <= left8);
        end
      end
    end else if (off_q == '0 && cnt_q == p8) begin
      // A whole-block set releases a tracked entry.
      vld_we = hit_found;
    end else if (!hit_found && !free_found) begin
      full_c = 1'b1;
    end else begin
      wr_en  = 1'b1;
      vld_we = 1'b1;
      if (map_mode == MODE_RANDOM) begin
        wr_bm = new_bm;
        if ((new_bm & pmask) != pmask) begin
          vld_val = 1'b1;
          ans_c   = 1'b1;
        end
      end else if (sum8 < p8) begin
        wr_cnt  = CNT_W'(sum8);
        vld_val = 1'b1;
        ans_c   = 1'b1;
      end
    end
  end

  // Sequencer next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = in_range_ok ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_idx == IDX_W'(ENTRIES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_RESP;
      ST_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode     <= MODE_RANDOM;
      pages_in_use <= CFG_W'(64);
    end else if (cfg_write) begin
      if (cfg_index == REG_MAP_MODE) begin
        map_mode <= cfg_data[0];
      end else begin
        pages_in_use <= cfg_data;
      end
    end
  end

  // Item capture and result registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_q  <= command;
      tag_q  <= block_address[TAG_W-1:0];
      off_q  <= in_off8;
      cnt_q  <= in_cnt8;
      ans_q  <= 1'b0;
      full_q <= 1'b0;
    end else if (state == ST_DECIDE) begin
      ans_q  <= ans_c;
      full_q <= full_c;
    end
  end

  assign answer     = ans_q;
  assign table_full = full_q;

  // Walk counter; the read data is registered, so cmp_idx and cmp_vld are registered to match it.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
    end else begin
      cmp_vld <= state == ST_SCAN;
      cmp_idx <= scan_idx;
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end else begin
        scan_idx <= '0;
      end
    end
  end

  // First matching entry and first free entry of the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_IDLE) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_vld) begin
      if (entry_valid[cmp_idx] && rd_tag == tag_q && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_bm    <= rd_bm;
        hit_cnt   <= rd_cnt;
      end
      if (!entry_valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  // Entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (state == ST_DECIDE && vld_we) begin
      entry_valid[wr_idx] <= vld_val;
    end
  end

endmodule
